FILE: hw/rtl/mcst_pkg.sv
// ----------------------------------------------------------------------------
// mcst_pkg
// Shared constants, codes and types of the multi-camera stream sync tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mcst_pkg;

    // Number of camera streams that must start before tags are grouped.
    localparam int NUM_CAMERAS  = 4;
    // Length of the reference-camera check window, in synced tags.
    localparam int WINDOW_LEN   = 8;
    // Tags per sync group.
    localparam int GROUP_LEN    = 4;

    localparam int CAM_IDX_W    = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
    localparam int PHASE_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    // Field widths.
    localparam int CAM_W        = 2;
    localparam int KIND_W       = 4;
    localparam int LEN_W        = 25;
    localparam int SEQ_W        = 32;
    localparam int GROUP_W      = 32;
    localparam int REF_CNT_W    = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 25;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0]     MIN_LEN_RESET  = LEN_W'(100);
    localparam logic [KIND_W-1:0]    KEY_CODE_RESET = KIND_W'(1);
    localparam logic [CAM_W-1:0]     REF_CAM_RESET  = CAM_W'(1);
    localparam logic [REF_CNT_W-1:0] MAX_REF_RESET  = REF_CNT_W'(2);

    // Reference count saturates here.
    localparam logic [REF_CNT_W-1:0] REF_COUNT_MAX  = '1;

    // Window phase values.
    localparam logic [PHASE_W-1:0]   PHASE_ONE      = PHASE_W'(1 % WINDOW_LEN);
    localparam logic [PHASE_W-1:0]   PHASE_LAST     = PHASE_W'(WINDOW_LEN - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_TAG_LENGTH   = 2'd0,
        CFG_KEY_FRAME_CODE   = 2'd1,
        CFG_REFERENCE_CAMERA = 2'd2,
        CFG_MAX_REF_COUNT    = 2'd3
    } t_cfg_idx;

    // Control from the tracker to the sequence checker.
    typedef struct packed {
        logic                 load;   // store the sequence number of this tag
        logic                 clear;  // forget all sequence history
        logic [CAM_IDX_W-1:0] cam;    // camera slot to check and update
    } t_seq_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/mcst_seq_check.sv
// ----------------------------------------------------------------------------
// mcst_seq_check
// Per-camera packet sequence history and gap detection.
// ----------------------------------------------------------------------------
`default_nettype none

module mcst_seq_check (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire mcst_pkg::t_seq_ctrl      i_ctrl,
    input  wire logic [mcst_pkg::SEQ_W-1:0] i_seq,
    output logic                          o_gap
);

    logic [mcst_pkg::SEQ_W-1:0] r_last_seq [mcst_pkg::NUM_CAMERAS];
    logic [mcst_pkg::SEQ_W-1:0] sel_seq;

    // A stored value of zero means no sequence number has been seen yet.
    assign sel_seq = r_last_seq[i_ctrl.cam];
    assign o_gap   = (sel_seq != '0) && ((sel_seq + 1'b1) != i_seq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mcst_pkg::NUM_CAMERAS; i++) begin
                r_last_seq[i] <= '0;
            end
        end else if (i_ctrl.clear) begin
            for (int i = 0; i < mcst_pkg::NUM_CAMERAS; i++) begin
                r_last_seq[i] <= '0;
            end
        end else if (i_ctrl.load) begin
            r_last_seq[i_ctrl.cam] <= i_seq;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/multi_camera_stream_sync_tracker.sv
// ----------------------------------------------------------------------------
// multi_camera_stream_sync_tracker
// Tracks start-up, grouping and window health of several camera tag streams.
// ----------------------------------------------------------------------------
// The tracker takes one video tag transaction per clock cycle while the input
// is not stalled and returns one result transaction for each, in order, in the
// cycle after acceptance. All the per-tag work (sequence compare, window check,
// start-up detection and group numbering) is done combinationally between the
// input handshake and the result register, so the state it leaves is ready for
// the next tag right away. The result register decouples the two sides: a new
// tag is taken whenever the result register is empty or its transaction is
// being taken in the same cycle. There is no start-up pass; tags are accepted
// directly after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_camera_stream_sync_tracker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [mcst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mcst_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    // Tag input channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [mcst_pkg::CAM_W-1:0]        i_cam_index,
    input  wire logic [mcst_pkg::KIND_W-1:0]       i_frame_kind,
    input  wire logic [mcst_pkg::LEN_W-1:0]        i_tag_len,
    input  wire logic [mcst_pkg::SEQ_W-1:0]        i_pkt_seq,

    // Result output channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_is_synced,
    output logic [mcst_pkg::GROUP_W-1:0]           o_group_number,
    output logic                                   o_seq_gap,
    output logic                                   o_resync,
    output logic                                   o_forward
);

    localparam int NCAM = mcst_pkg::NUM_CAMERAS;

    // Configuration registers.
    logic [mcst_pkg::LEN_W-1:0]     r_min_len;
    logic [mcst_pkg::KIND_W-1:0]    r_key_code;
    logic [mcst_pkg::CAM_W-1:0]     r_ref_cam;
    logic [mcst_pkg::REF_CNT_W-1:0] r_max_ref;

    // Sync state.
    logic [NCAM-1:0]                r_cam_started, n_cam_started;
    logic                           r_all_started, n_all_started;
    logic [mcst_pkg::GROUP_W-1:0]   r_tag_counter, n_tag_counter;
    logic [mcst_pkg::PHASE_W-1:0]   r_win_phase,   n_win_phase;
    logic [mcst_pkg::REF_CNT_W-1:0] r_ref_count,   n_ref_count;

    // Result register.
    logic                           r_out_valid;
    logic                           r_is_synced;
    logic [mcst_pkg::GROUP_W-1:0]   r_group_number;
    logic                           r_seq_gap;
    logic                           r_resync;
    logic                           r_forward;

    logic                           in_acc;
    logic                           cam_ok;
    logic [mcst_pkg::CAM_IDX_W-1:0] cam_sel;
    logic [NCAM-1:0]                cam_mask;
    logic                           ref_hit;
    logic                           window_end;
    logic                           resync;
    logic                           synced;
    logic [NCAM-1:0]                started_cur;
    logic                           start;
    logic                           gap;
    logic [mcst_pkg::GROUP_W-1:0]   group;
    mcst_pkg::t_seq_ctrl            seq_ctrl;

    // The input side waits only while a finished result is held back.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len  <= mcst_pkg::MIN_LEN_RESET;
            r_key_code <= mcst_pkg::KEY_CODE_RESET;
            r_ref_cam  <= mcst_pkg::REF_CAM_RESET;
            r_max_ref  <= mcst_pkg::MAX_REF_RESET;
        end else if (i_cfg_we) begin
            case (mcst_pkg::t_cfg_idx'(i_cfg_index))
                mcst_pkg::CFG_MIN_TAG_LENGTH: begin
                    r_min_len <= i_cfg_data[mcst_pkg::LEN_W-1:0];
                end
                mcst_pkg::CFG_KEY_FRAME_CODE: begin
                    r_key_code <= i_cfg_data[mcst_pkg::KIND_W-1:0];
                end
                mcst_pkg::CFG_REFERENCE_CAMERA: begin
                    r_ref_cam <= i_cfg_data[mcst_pkg::CAM_W-1:0];
                end
                mcst_pkg::CFG_MAX_REF_COUNT: begin
                    r_max_ref <= i_cfg_data[mcst_pkg::REF_CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Camera decode. Tags from a camera index beyond the configured count
    // are answered with an all-zero result and leave the state untouched.
    assign cam_ok   = (32'(i_cam_index) < NCAM);
    assign cam_sel  = mcst_pkg::CAM_IDX_W'(i_cam_index);
    assign cam_mask = NCAM'(1) << cam_sel;
    assign ref_hit  = cam_ok && (i_cam_index == r_ref_cam);

    // The window phase mirrors the tag counter modulo the window length.
    // A window closes on a tag whose counter value is a multiple of it; the
    // reference camera must have appeared at least once and no more than
    // the configured maximum during the window, otherwise everything restarts.
    assign window_end = (r_win_phase == '0);
    assign resync     = cam_ok && r_all_started && window_end &&
                        ((r_ref_count > r_max_ref) || (r_ref_count == '0));
    assign synced     = cam_ok && r_all_started && !resync;
    assign group      = synced ? (r_tag_counter / mcst_pkg::GROUP_LEN) + 1'b1 : '0;

    // A resync clears the start flags before this tag's own key frame check,
    // so the tag that triggers it may already start its camera again.
    assign started_cur = resync ? '0 : r_cam_started;
    assign start       = cam_ok && !started_cur[cam_sel] &&
                         (i_frame_kind == r_key_code) && (i_tag_len >= r_min_len);

    always_comb begin
        n_cam_started = r_cam_started;
        n_all_started = r_all_started;
        n_tag_counter = r_tag_counter;
        n_win_phase   = r_win_phase;
        n_ref_count   = r_ref_count;

        if (in_acc && cam_ok) begin
            if (r_all_started) begin
                if (!window_end) begin
                    if (ref_hit && (r_ref_count != mcst_pkg::REF_COUNT_MAX)) begin
                        n_ref_count = r_ref_count + 1'b1;
                    end
                end else begin
                    n_ref_count = '0;
                end
            end

            if (synced) begin
                n_tag_counter = r_tag_counter + 1'b1;
                // Counter wrap brings the phase back to zero as well.
                if ((r_tag_counter == '1) || (r_win_phase == mcst_pkg::PHASE_LAST)) begin
                    n_win_phase = '0;
                end else begin
                    n_win_phase = r_win_phase + 1'b1;
                end
            end

            if (resync) begin
                n_all_started = 1'b0;
                n_tag_counter = '0;
                n_win_phase   = '0;
            end

            n_cam_started = started_cur | (start ? cam_mask : '0);
            if (start && (&(started_cur | cam_mask))) begin
                n_all_started = 1'b1;
                n_tag_counter = mcst_pkg::GROUP_W'(1);
                n_win_phase   = mcst_pkg::PHASE_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_started <= '0;
            r_all_started <= 1'b0;
            r_tag_counter <= '0;
            r_win_phase   <= '0;
            r_ref_count   <= '0;
        end else begin
            r_cam_started <= n_cam_started;
            r_all_started <= n_all_started;
            r_tag_counter <= n_tag_counter;
            r_win_phase   <= n_win_phase;
            r_ref_count   <= n_ref_count;
        end
    end

    // Sequence history: stored on every in-range tag, wiped on resync.
    assign seq_ctrl.load  = in_acc && cam_ok;
    assign seq_ctrl.clear = in_acc && resync;
    assign seq_ctrl.cam   = cam_sel;

    mcst_seq_check u_seq_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (seq_ctrl),
        .i_seq   (i_pkt_seq),
        .o_gap   (gap)
    );

    // Result register. Payload loads only with an accepted tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= in_acc || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_is_synced    <= synced;
            r_group_number <= group;
            r_seq_gap      <= cam_ok && gap;
            r_resync       <= resync;
            r_forward      <= cam_ok && n_cam_started[cam_sel];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_synced    = r_is_synced;
    assign o_group_number = r_group_number;
    assign o_seq_gap      = r_seq_gap;
    assign o_resync       = r_resync;
    assign o_forward      = r_forward;

    // A resync tag is never reported as synced.
    a_resync_not_synced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_resync) |-> !o_is_synced)
        else $error("resync transaction reported as synced");

    // A synced tag always comes from a started camera.
    a_synced_forward : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_synced) |-> o_forward)
        else $error("synced transaction not forwarded");

    // Group numbers are nonzero exactly for synced tags.
    a_group_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_synced == (o_group_number != '0)))
        else $error("group number disagrees with sync flag");

    // The global start flag implies every camera has started.
    a_all_started : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_all_started |-> (&r_cam_started))
        else $error("all-started set with a camera still waiting");

    // The tag counter restarts at one when the global start flag rises.
    a_phase_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_all_started)) |-> (r_tag_counter == mcst_pkg::GROUP_W'(1)))
        else $error("tag counter not restarted at sync");

endmodule

`default_nettype wire
